[hw/rtl/ntsd_pkg.sv]
// ----------------------------------------------------------------------------
// ntsd_pkg: shared types and constants of the nested TLV status decoder
// Parser phases, result kinds and the job descriptor passed from the
// parser front end to the result sequencer.
// ----------------------------------------------------------------------------
package ntsd_pkg;

  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  localparam logic [1:0] KIND_COOK  = 2'd0;
  localparam logic [1:0] KIND_MAIN  = 2'd1;
  localparam logic [1:0] KIND_EXTRA = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [7:0] TAG_TARGET = 8'd1;
  localparam logic [7:0] TAG_DISPLAY = 8'd2;
  localparam logic [7:0] TAG_PROBE  = 8'd4;
  localparam logic [7:0] TAG_ACTUAL = 8'd13;

  localparam logic [7:0] ITAG_SLOT    = 8'd1;
  localparam logic [7:0] ITAG_LEGACY  = 8'd4;
  localparam logic [7:0] ITAG_TEMP    = 8'd10;
  localparam logic [7:0] ITAG_STATE   = 8'd12;
  localparam logic [7:0] ITAG_TYPE    = 8'd19;
  localparam logic [7:0] ITAG_BATTERY = 8'd22;
  localparam logic [7:0] ITAG_SEGMENT = 8'd23;
  localparam logic [7:0] ITAG_CASE    = 8'd24;
  localparam logic [7:0] ITAG_AMBIENT = 8'd25;

  localparam logic [15:0] TEMP_INVALID = 16'h8000;

  localparam int SEG_OUT_CAP = 4;
  localparam int QUEUE_DEPTH = 4;

  // Everything one input item causes, in one queue entry.
  typedef struct packed {
    logic        has_cook;
    logic        has_probe;
    logic        has_end;
    logic [1:0]  cook_code;
    logic [15:0] cook_temp;
    logic [2:0]  slot;
    logic [7:0]  state;
    logic [15:0] temp;
    logic        temp_valid;
    logic [7:0]  ptype;
    logic [7:0]  battery;
    logic        battery_valid;
    logic [15:0] case_t;
    logic        case_valid;
    logic [15:0] amb_t;
    logic        amb_valid;
    logic [2:0]  nseg;
    logic [SEG_OUT_CAP-1:0][15:0] seg;
    logic [3:0]  count;
    logic        err;
  } ntsd_desc_t;

endpackage

[hw/rtl/ntsd_front.sv]
// ----------------------------------------------------------------------------
// ntsd_front: byte parser
// Walks the outer and nested TLV records one byte per cycle while input is accepted,
// and builds one job descriptor for every input item that causes results.
// ----------------------------------------------------------------------------
module ntsd_front #(
  parameter int PROBE_SLOTS = 8,
  parameter int SEGMENTS    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                last_byte,
  output logic                push,
  output ntsd_pkg::ntsd_desc_t desc
);
  import ntsd_pkg::*;

  localparam int SC_W = $clog2(SEGMENTS + 1);

  typedef struct packed {
    logic [7:0]  slot;
    logic        slot_known;
    logic [7:0]  state;
    logic [7:0]  type19;
    logic        type19_seen;
    logic [7:0]  legacy_type;
    logic [15:0] temp;
    logic        temp_valid;
    logic [7:0]  battery;
    logic        battery_valid;
    logic [15:0] case_t;
    logic        case_valid;
    logic [15:0] amb_t;
    logic        amb_valid;
  } probe_t;

  logic [1:0]  oph_r, oph_nxt, iph_r, iph_nxt;
  logic [7:0]  otag_r, otag_nxt, itag_r, itag_nxt;
  logic [7:0]  orem_r, orem_nxt, irem_r, irem_nxt;
  logic [1:0]  oidx_r, oidx_nxt, iidx_r, iidx_nxt;
  logic [7:0]  hold_r, hold_nxt;
  probe_t      pf_r, pf_nxt;
  logic [15:0] seg_r [SEGMENTS];
  logic [15:0] seg_nxt [SEGMENTS];
  logic [SC_W-1:0] segcnt_r, segcnt_nxt;
  logic [7:0]  map_r, map_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  rem_after;
  logic [15:0] word;
  logic        inner_err;
  logic        probe_done;

  always_comb begin
    oph_nxt = oph_r; iph_nxt = iph_r;
    otag_nxt = otag_r; itag_nxt = itag_r;
    orem_nxt = orem_r; irem_nxt = irem_r;
    oidx_nxt = oidx_r; iidx_nxt = iidx_r;
    hold_nxt = hold_r; pf_nxt = pf_r;
    seg_nxt = seg_r; segcnt_nxt = segcnt_r;
    map_nxt = map_r; cnt_nxt = cnt_r; err_nxt = err_r;
    desc = '0;
    inner_err = 1'b0;
    probe_done = 1'b0;
    rem_after = orem_r - 8'd1;
    word = {data_byte, hold_r};
    if (accept) begin
      if (byte_present && !err_r) begin
        case (oph_r)
          PH_TAG: begin
            otag_nxt = data_byte;
            oph_nxt = PH_LEN;
          end
          PH_LEN: begin
            orem_nxt = data_byte;
            oidx_nxt = 2'd0;
            if (otag_r == TAG_PROBE) begin
              pf_nxt = '0;
              segcnt_nxt = '0;
              iph_nxt = PH_TAG;
              irem_nxt = 8'd0;
              iidx_nxt = 2'd0;
            end
            if (data_byte == 8'd0) begin
              oph_nxt = PH_TAG;
              probe_done = (otag_r == TAG_PROBE);
            end else begin
              oph_nxt = PH_VAL;
            end
          end
          default: begin
            if (otag_r == TAG_PROBE) begin
              case (iph_r)
                PH_TAG: begin
                  itag_nxt = data_byte;
                  iph_nxt = PH_LEN;
                  inner_err = (rem_after == 8'd0);
                end
                PH_LEN: begin
                  if (data_byte > rem_after) begin
                    inner_err = 1'b1;
                  end else begin
                    irem_nxt = data_byte;
                    iidx_nxt = 2'd0;
                    iph_nxt = (data_byte == 8'd0) ? PH_TAG : PH_VAL;
                  end
                end
                default: begin
                  if (iidx_r == 2'd0) begin
                    hold_nxt = data_byte;
                    case (itag_r)
                      ITAG_SLOT: begin
                        pf_nxt.slot = data_byte; pf_nxt.slot_known = 1'b1;
                      end
                      ITAG_LEGACY: pf_nxt.legacy_type = data_byte;
                      ITAG_STATE: pf_nxt.state = data_byte;
                      ITAG_TYPE: begin
                        pf_nxt.type19 = data_byte; pf_nxt.type19_seen = 1'b1;
                      end
                      ITAG_BATTERY: begin
                        pf_nxt.battery = data_byte; pf_nxt.battery_valid = 1'b1;
                      end
                      default: ;
                    endcase
                  end else if (iidx_r == 2'd1) begin
                    case (itag_r)
                      ITAG_TEMP: begin
                        pf_nxt.temp = word; pf_nxt.temp_valid = (word != TEMP_INVALID);
                      end
                      ITAG_SEGMENT: begin
                        if (segcnt_r < SC_W'(SEGMENTS)) begin
                          for (int i = 0; i < SEGMENTS; i++) begin
                            if (segcnt_r == SC_W'(i)) seg_nxt[i] = word;
                          end
                          segcnt_nxt = segcnt_r + 1'b1;
                        end
                      end
                      ITAG_CASE: begin
                        pf_nxt.case_t = word; pf_nxt.case_valid = (word != TEMP_INVALID);
                      end
                      ITAG_AMBIENT: begin
                        pf_nxt.amb_t = word; pf_nxt.amb_valid = (word != TEMP_INVALID);
                      end
                      default: ;
                    endcase
                  end
                  if (iidx_r != 2'd2) iidx_nxt = iidx_r + 2'd1;
                  irem_nxt = irem_r - 8'd1;
                  if (irem_r == 8'd1) iph_nxt = PH_TAG;
                end
              endcase
            end else if (otag_r == TAG_TARGET || otag_r == TAG_DISPLAY ||
                         otag_r == TAG_ACTUAL) begin
              if (oidx_r == 2'd0) begin
                hold_nxt = data_byte;
              end else if (oidx_r == 2'd1) begin
                desc.has_cook = 1'b1;
                desc.cook_temp = word;
                desc.cook_code = (otag_r == TAG_TARGET) ? 2'd0 :
                                 (otag_r == TAG_DISPLAY) ? 2'd1 : 2'd2;
              end
            end
            if (inner_err) begin
              err_nxt = 1'b1;
            end else begin
              if (oidx_r != 2'd2) oidx_nxt = oidx_r + 2'd1;
              orem_nxt = rem_after;
              if (rem_after == 8'd0) begin
                oph_nxt = PH_TAG;
                probe_done = (otag_r == TAG_PROBE);
              end
            end
          end
        endcase
      end

      // A finished probe record with a usable slot becomes a burst of results.
      if (probe_done && pf_nxt.slot_known && pf_nxt.slot < 8'(PROBE_SLOTS)) begin
        if (!map_nxt[pf_nxt.slot[2:0]]) begin
          map_nxt[pf_nxt.slot[2:0]] = 1'b1;
          cnt_nxt = cnt_nxt + 4'd1;
        end
        desc.has_probe = 1'b1;
        desc.slot = pf_nxt.slot[2:0];
        desc.state = pf_nxt.state;
        desc.temp = pf_nxt.temp;
        desc.temp_valid = pf_nxt.temp_valid;
        desc.ptype = (!pf_nxt.type19_seen || pf_nxt.type19 == 8'd0) ?
                     pf_nxt.legacy_type : pf_nxt.type19;
        desc.battery = pf_nxt.battery;
        desc.battery_valid = pf_nxt.battery_valid;
        desc.case_t = pf_nxt.case_t;
        desc.case_valid = pf_nxt.case_valid;
        desc.amb_t = pf_nxt.amb_t;
        desc.amb_valid = pf_nxt.amb_valid;
        desc.nseg = (int'(segcnt_nxt) > SEG_OUT_CAP) ? 3'(SEG_OUT_CAP) : 3'(segcnt_nxt);
        for (int i = 0; i < SEG_OUT_CAP; i++) begin
          if (i < SEGMENTS) desc.seg[i] = seg_nxt[i % SEGMENTS];
        end
      end
      desc.count = cnt_nxt;

      if (last_byte) begin
        desc.has_end = 1'b1;
        desc.err = err_nxt || (oph_nxt != PH_TAG);
        oph_nxt = PH_TAG; iph_nxt = PH_TAG;
        otag_nxt = '0; itag_nxt = '0;
        orem_nxt = '0; irem_nxt = '0;
        oidx_nxt = '0; iidx_nxt = '0;
        hold_nxt = '0; pf_nxt = '0;
        segcnt_nxt = '0; map_nxt = '0; cnt_nxt = '0; err_nxt = 1'b0;
      end
    end
    push = desc.has_cook || desc.has_probe || desc.has_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oph_r <= PH_TAG; iph_r <= PH_TAG;
      otag_r <= '0; itag_r <= '0;
      orem_r <= '0; irem_r <= '0;
      oidx_r <= '0; iidx_r <= '0;
      hold_r <= '0; pf_r <= '0;
      segcnt_r <= '0; map_r <= '0; cnt_r <= '0; err_r <= 1'b0;
    end else begin
      oph_r <= oph_nxt; iph_r <= iph_nxt;
      otag_r <= otag_nxt; itag_r <= itag_nxt;
      orem_r <= orem_nxt; irem_r <= irem_nxt;
      oidx_r <= oidx_nxt; iidx_r <= iidx_nxt;
      hold_r <= hold_nxt; pf_r <= pf_nxt;
      segcnt_r <= segcnt_nxt; map_r <= map_nxt; cnt_r <= cnt_nxt; err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

endmodule

[hw/rtl/ntsd_queue.sv]
// ----------------------------------------------------------------------------
// ntsd_queue: job descriptor queue
// Small register FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module ntsd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ntsd_pkg::ntsd_desc_t push_desc,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output ntsd_pkg::ntsd_desc_t head
);
  import ntsd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  ntsd_desc_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]       wp_r, rp_r;
  logic [PW:0]         cnt_r;

  assign full      = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_desc;
  end

endmodule

[hw/rtl/ntsd_back.sv]
// ----------------------------------------------------------------------------
// ntsd_back: result sequencer
// Expands the job at the queue head into result items, one per cycle while the output
// is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ntsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  ntsd_pkg::ntsd_desc_t job,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);
  import ntsd_pkg::*;

  logic [2:0]  step_r, step_nxt;
  logic        ov_r;
  logic [55:0] data_r;
  logic [1:0]  kind_r;
  logic        last_r;

  logic        load;
  logic [3:0]  total;
  logic [3:0]  k;
  logic [1:0]  kind;
  logic [2:0]  slot;
  logic [7:0]  code;
  logic [15:0] temp;
  logic        tv;
  logic [7:0]  ptype, batt;
  logic        bv;
  logic        is_last;
  logic [1:0]  si;

  assign load = job_valid && (!ov_r || out_tready);

  always_comb begin
    k = {1'b0, step_r};
    total = (job.has_cook ? 4'd1 : 4'd0) +
            (job.has_probe ? 4'd3 + {1'b0, job.nseg} : 4'd0) +
            (job.has_end ? 4'd1 : 4'd0);
    kind = KIND_END; slot = '0; code = '0; temp = '0; tv = 1'b0;
    ptype = '0; batt = '0; bv = 1'b0;
    si = 2'(k - 4'd3);
    if (job.has_cook && k == 4'd0) begin
      kind = KIND_COOK;
      code = {6'd0, job.cook_code};
      temp = job.cook_temp;
      tv = (job.cook_temp != TEMP_INVALID);
    end else if (job.has_probe && k < 4'd3 + {1'b0, job.nseg}) begin
      slot = job.slot;
      if (k == 4'd0) begin
        kind = KIND_MAIN; code = job.state; temp = job.temp; tv = job.temp_valid;
        ptype = job.ptype; batt = job.battery; bv = job.battery_valid;
      end else if (k == 4'd1) begin
        kind = KIND_EXTRA; code = 8'd0; temp = job.case_t; tv = job.case_valid;
      end else if (k == 4'd2) begin
        kind = KIND_EXTRA; code = 8'd1; temp = job.amb_t; tv = job.amb_valid;
      end else begin
        kind = KIND_EXTRA;
        code = 8'd2 + {6'd0, si};
        temp = job.seg[si];
        tv = (job.seg[si] != TEMP_INVALID);
      end
    end else begin
      code = {7'd0, job.err};
    end
    is_last = (k == total - 4'd1);
    pop = load && is_last;
    step_nxt = step_r;
    if (load) step_nxt = is_last ? 3'd0 : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      ov_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {7'd0, job.count, bv, batt, ptype, tv, temp, code, slot};
      kind_r <= kind;
      last_r <= is_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

[hw/rtl/nested_tlv_status_decoder.sv]
// Job descriptors pass through the queue to the registered output stage.
// Throughput: one input item per cycle; the sequencer emits one result per cycle,
// so a probe record end (up to eight results) holds the four-entry job queue.
// Input is stalled only while that queue is full.
// Reset (rst_n low, synchronous) clears the parser, the queue and the output stage.
// ----------------------------------------------------------------------------
// nested_tlv_status_decoder: nested TLV status decoder top level
// Parser front end, job queue and result sequencer.
// ----------------------------------------------------------------------------
module nested_tlv_status_decoder #(
  parameter int PROBE_SLOTS = 8,
  parameter int SEGMENTS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [0:0]  in_tuser,   // byte_present[0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot[2:0], code[10:3], temperature[26:11], temp_ok[27],
  // ptype[35:28], batt_pct[43:36], batt_ok[44], n_present[48:45]
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);
  import ntsd_pkg::*;

  logic       accept, push, full, not_empty, pop;
  ntsd_desc_t desc, head;

  assign in_tready = !full;
  assign accept = in_tvalid && in_tready;

  ntsd_front #(.PROBE_SLOTS(PROBE_SLOTS), .SEGMENTS(SEGMENTS)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept),
    .data_byte(in_tdata), .byte_present(in_tuser[0]), .last_byte(in_tlast),
    .push(push), .desc(desc)
  );

  ntsd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_desc(desc), .pop(pop),
    .full(full), .not_empty(not_empty), .head(head)
  );

  ntsd_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(not_empty), .job(head), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule

[hw/rtl/ntsd_checker.sv]
// ----------------------------------------------------------------------------
// ntsd_checker: port-level checks of the nested TLV status decoder
// Watches the top-level ports and flags protocol and result-format slips.
// ----------------------------------------------------------------------------
module ntsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import ntsd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tlast)
    else $error("end status item is not the last one");

  a_cook_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_COOK || out_tuser == KIND_END)
      |-> out_tdata[2:0] == 3'd0 && out_tdata[44:28] == '0)
    else $error("probe fields set on a non-probe item");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind nested_tlv_status_decoder ntsd_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the nested TLV status decoder
// Feeds payloads built from cook temperature and probe records, with
// truncated and random payloads mixed in. A behavioral decoder predicts
// every result item, and a monitor compares each item with the oldest one.
// Sender gaps and receiver stalls change by phase.
// ----------------------------------------------------------------------------
module testbench;
  import ntsd_pkg::*;

  localparam int NSLOTS = 8;
  localparam int NSEG   = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [7:0]  code;
    logic [15:0] temperature;
    logic        temp_ok;
    logic [7:0]  ptype;
    logic [7:0]  batt_pct;
    logic        batt_ok;
    logic [3:0]  n_present;
    logic        last;
  } status_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte[7:0]
  logic [0:0]  in_tuser;   // byte_present[0]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  // slot[2:0], code[10:3], temperature[26:11], temp_ok[27],
  // ptype[35:28], batt_pct[43:36], batt_ok[44], n_present[48:45]
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;  // kind[1:0]
  logic        out_tlast;

  nested_tlv_status_decoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Decoder state of the prediction.
  logic [1:0]  o_phase, i_phase;
  logic [7:0]  o_tag, o_rem, o_idx, i_tag, i_rem, i_idx, lo_hold;
  logic [2:0]  p_slot_lo;
  logic [7:0]  p_slot, p_state, p_type19, p_legacy, p_batt;
  logic        p_slot_known, p_type19_seen, p_temp_ok, p_batt_ok, p_case_ok, p_amb_ok;
  logic [15:0] p_temp, p_case, p_amb;
  logic [15:0] seg_vals [NSEG];
  int          seg_cnt;
  logic [7:0]  present_map;
  logic [3:0]  present_cnt;
  logic        parse_err;

  byte_item_t  pending_bytes[$];
  status_rec_t expected_recs[$];
  int          fail_count = 0;
  int          idle_pct_in, idle_pct_out;
  logic        hold_off;
  int          hold_cnt;
  int          watchdog;

  task automatic clear_decoder();
    o_phase = PH_TAG; i_phase = PH_TAG;
    o_tag = 0; o_rem = 0; o_idx = 0; i_tag = 0; i_rem = 0; i_idx = 0; lo_hold = 0;
    clear_probe();
    present_map = 0; present_cnt = 0; parse_err = 0;
  endtask

  task automatic clear_probe();
    p_slot = 0; p_state = 0; p_type19 = 0; p_legacy = 0; p_batt = 0;
    p_slot_known = 0; p_type19_seen = 0; p_temp_ok = 0; p_batt_ok = 0;
    p_case_ok = 0; p_amb_ok = 0; p_temp = 0; p_case = 0; p_amb = 0;
    seg_cnt = 0;
  endtask

  task automatic push_rec(logic [1:0] kind, logic [2:0] slot, logic [7:0] code,
                          logic [15:0] t, logic tv, logic [7:0] pt,
                          logic [7:0] bat, logic bv);
    status_rec_t r;
    r = '{kind, slot, code, t, tv, pt, bat, bv, present_cnt, 1'b0};
    expected_recs.push_back(r);
  endtask

  task automatic close_probe();
    logic [7:0] pt;
    if (!p_slot_known || p_slot >= NSLOTS) return;
    p_slot_lo = p_slot[2:0];
    if (!present_map[p_slot_lo]) begin
      present_map[p_slot_lo] = 1'b1;
      present_cnt++;
    end
    pt = (!p_type19_seen || p_type19 == 0) ? p_legacy : p_type19;
    push_rec(KIND_MAIN, p_slot_lo, p_state, p_temp, p_temp_ok, pt, p_batt, p_batt_ok);
    push_rec(KIND_EXTRA, p_slot_lo, 8'd0, p_case, p_case_ok, 0, 0, 0);
    push_rec(KIND_EXTRA, p_slot_lo, 8'd1, p_amb, p_amb_ok, 0, 0, 0);
    for (int i = 0; i < seg_cnt && i < SEG_OUT_CAP; i++)
      push_rec(KIND_EXTRA, p_slot_lo, 8'(2 + i), seg_vals[i],
               seg_vals[i] != TEMP_INVALID, 0, 0, 0);
  endtask

  task automatic probe_byte(logic [7:0] b, logic [7:0] rem_after);
    logic [15:0] v;
    if (i_phase == PH_TAG) begin
      i_tag = b;
      i_phase = PH_LEN;
      if (rem_after == 0) parse_err = 1'b1;
    end else if (i_phase == PH_LEN) begin
      if (b > rem_after) begin
        parse_err = 1'b1;
        return;
      end
      i_rem = b; i_idx = 0;
      i_phase = (b == 0) ? PH_TAG : PH_VAL;
    end else begin
      if (i_idx == 0) begin
        lo_hold = b;
        case (i_tag)
          ITAG_SLOT: begin p_slot = b; p_slot_known = 1'b1; end
          ITAG_LEGACY: p_legacy = b;
          ITAG_STATE: p_state = b;
          ITAG_TYPE: begin p_type19 = b; p_type19_seen = 1'b1; end
          ITAG_BATTERY: begin p_batt = b; p_batt_ok = 1'b1; end
          default: ;
        endcase
      end else if (i_idx == 1) begin
        v = {b, lo_hold};
        case (i_tag)
          ITAG_TEMP: begin p_temp = v; p_temp_ok = v != TEMP_INVALID; end
          ITAG_SEGMENT: if (seg_cnt < NSEG) begin
            seg_vals[seg_cnt] = v;
            seg_cnt++;
          end
          ITAG_CASE: begin p_case = v; p_case_ok = v != TEMP_INVALID; end
          ITAG_AMBIENT: begin p_amb = v; p_amb_ok = v != TEMP_INVALID; end
          default: ;
        endcase
      end
      if (i_idx < 255) i_idx++;
      i_rem--;
      if (i_rem == 0) i_phase = PH_TAG;
    end
  endtask

  task automatic payload_byte(logic [7:0] b);
    logic [7:0]  rem_after;
    logic [15:0] v;
    if (o_phase == PH_TAG) begin
      o_tag = b;
      o_phase = PH_LEN;
    end else if (o_phase == PH_LEN) begin
      o_rem = b; o_idx = 0;
      if (o_tag == TAG_PROBE) begin
        clear_probe();
        i_phase = PH_TAG; i_rem = 0; i_idx = 0;
      end
      if (b == 0) begin
        o_phase = PH_TAG;
        if (o_tag == TAG_PROBE) close_probe();
      end else begin
        o_phase = PH_VAL;
      end
    end else begin
      rem_after = o_rem - 8'd1;
      if (o_tag == TAG_PROBE) begin
        probe_byte(b, rem_after);
        if (parse_err) return;
      end else if (o_tag == TAG_TARGET || o_tag == TAG_DISPLAY || o_tag == TAG_ACTUAL) begin
        if (o_idx == 0) begin
          lo_hold = b;
        end else if (o_idx == 1) begin
          v = {b, lo_hold};
          push_rec(KIND_COOK, 3'd0,
                   o_tag == TAG_TARGET ? 8'd0 : (o_tag == TAG_DISPLAY ? 8'd1 : 8'd2),
                   v, v != TEMP_INVALID, 0, 0, 0);
        end
      end
      if (o_idx < 255) o_idx++;
      o_rem = rem_after;
      if (o_rem == 0) begin
        o_phase = PH_TAG;
        if (o_tag == TAG_PROBE) close_probe();
      end
    end
  endtask

  // Predicts the result items of one accepted input item.
  task automatic predict_item(byte_item_t it);
    int n0;
    n0 = expected_recs.size();
    if (it.present && !parse_err) payload_byte(it.data);
    if (it.last) begin
      push_rec(KIND_END, 3'd0, (parse_err || o_phase != PH_TAG) ? 8'd1 : 8'd0,
               0, 0, 0, 0, 0);
      clear_decoder();
    end
    if (expected_recs.size() > n0) expected_recs[$].last = 1'b1;
  endtask

  function automatic string rec_str(status_rec_t r);
    return $sformatf(
      "kind=%0d slot=%0d code=%0d t=%h tv=%b pt=%0d bat=%0d bv=%b cnt=%0d last=%b",
      r.kind, r.slot, r.code, r.temperature, r.temp_ok, r.ptype, r.batt_pct,
      r.batt_ok, r.n_present, r.last);
  endfunction

  // ---------------- stimulus building ----------------
  byte_item_t frame[$];

  task automatic add_byte(logic [7:0] b);
    frame.push_back('{b, 1'b1, 1'b0});
  endtask

  task automatic add_rec(logic [7:0] tag, logic [7:0] len, logic [15:0] val);
    add_byte(tag); add_byte(len);
    for (int i = 0; i < len; i++)
      add_byte(i == 0 ? val[7:0] : (i == 1 ? val[15:8] : 8'($urandom)));
  endtask

  function automatic logic [15:0] rand_temp();
    case ($urandom_range(0, 5))
      0: return TEMP_INVALID;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Builds one probe record, header and body, into frame.
  task automatic add_probe(int slot, bit full, int nseg);
    byte_item_t body[$];
    byte_item_t saved[$];
    saved = frame;
    frame = {};
    if (slot >= 0) add_rec(ITAG_SLOT, 8'($urandom_range(1, 2)), 16'(slot));
    if (full || $urandom_range(0, 1)) add_rec(ITAG_STATE, 1, 16'($urandom));
    if (full || $urandom_range(0, 1)) add_rec(ITAG_TEMP, 8'($urandom_range(1, 3)), rand_temp());
    if (full || $urandom_range(0, 1)) add_rec(ITAG_LEGACY, 8'($urandom_range(0, 1)), 16'($urandom));
    if (full || $urandom_range(0, 1))
      add_rec(ITAG_TYPE, 1, $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom));
    if (full || $urandom_range(0, 1)) add_rec(ITAG_BATTERY, 1, 16'($urandom));
    if (full || $urandom_range(0, 1)) add_rec(ITAG_CASE, 2, rand_temp());
    if (full || $urandom_range(0, 1)) add_rec(ITAG_AMBIENT, 2, rand_temp());
    for (int i = 0; i < nseg; i++) add_rec(ITAG_SEGMENT, 2, rand_temp());
    if ($urandom_range(0, 3) == 0) add_rec(8'($urandom), 8'($urandom_range(0, 3)), 16'($urandom));
    body = frame;
    frame = saved;
    add_byte(TAG_PROBE);
    add_byte(8'(body.size()));
    foreach (body[i]) frame.push_back(body[i]);
  endtask

  task automatic add_cook();
    logic [7:0] tags [3];
    tags = '{TAG_TARGET, TAG_DISPLAY, TAG_ACTUAL};
    add_rec(tags[$urandom_range(0, 2)], 8'($urandom_range(0, 3)), rand_temp());
  endtask

  // Sends the frame with tlast on its final byte; an empty frame sends a bare end.
  task automatic send_frame();
    if (frame.size() == 0) frame.push_back('{8'($urandom), 1'b0, 1'b0});
    if ($urandom_range(0, 4) == 0)
      frame.push_back('{8'($urandom), 1'b0, 1'b0});  // empty step at the end, carrying tlast
    frame[$].last = 1'b1;
    foreach (frame[i]) pending_bytes.push_back(frame[i]);
    frame = {};
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_recs.size() != 0) @(posedge clk);
  endtask

  // ---------------- driver ----------------
  // The item at the head of pending_bytes is the one on the bus until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      in_tlast <= 1'b0;
      clear_decoder();
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        predict_item('{in_tdata, in_tuser[0], in_tlast});
        void'(pending_bytes.pop_front());
      end
      if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct_in) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_bytes[0].data;
        in_tuser <= pending_bytes[0].present;
        in_tlast <= pending_bytes[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    status_rec_t got, exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[2:0], out_tdata[10:3], out_tdata[26:11], out_tdata[27],
              out_tdata[35:28], out_tdata[43:36], out_tdata[44], out_tdata[48:45], out_tlast};
      if (expected_recs.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %s", $time, rec_str(got));
        fail_count++;
      end else begin
        exp_rec = expected_recs.pop_front();
        if (got !== exp_rec) begin
          $display("%0t: mismatch expected %s", $time, rec_str(exp_rec));
          $display("%0t: mismatch actual   %s", $time, rec_str(got));
          fail_count++;
        end
      end
    end
  end

  // Receiver readiness; once hold_off is raised, it stays low for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_off && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct_out);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      watchdog <= 0;
    end else if (pending_bytes.size() != 0 || expected_recs.size() != 0) begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("nested_tlv_status_decoder test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    idle_pct_in = 0; idle_pct_out = 0; hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, every tag, type fallback, truncation, empty end.
    add_rec(TAG_TARGET, 2, 16'h8000); add_rec(TAG_DISPLAY, 1, 16'h0055);
    add_rec(TAG_ACTUAL, 3, 16'h7fff);
    send_frame();
    add_probe(7, 1, 5);
    add_probe(8, 0, 0);     // slot out of range
    add_probe(-1, 0, 1);    // no slot at all
    send_frame();
    send_frame();           // empty payload
    add_byte(TAG_PROBE); add_byte(8'd3); add_byte(ITAG_CASE); add_byte(8'd5); add_byte(8'hff);
    send_frame();           // inner length beyond the record
    add_byte(TAG_PROBE); add_byte(8'd1); add_byte(ITAG_SLOT);
    send_frame();           // inner header cut
    add_byte(TAG_ACTUAL); add_byte(8'd4); add_byte(8'h00);
    send_frame();           // outer record unfinished
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
        1: begin idle_pct_in = 48; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 48; end
        3: begin idle_pct_in = 36; idle_pct_out = 36; end
        default: begin idle_pct_in = 0; idle_pct_out = 0; end
      endcase
      if (ph == 4) begin
        // Short cook records back to back fill the job queue while the
        // receiver holds off.
        repeat (6) add_rec(TAG_TARGET, 8'd2, rand_temp());
        send_frame();
        hold_off = 1'b1;
      end else begin
        if ($urandom_range(0, 2) != 0)
          add_probe($urandom_range(0, 9) == 0 ? 8 + $urandom_range(0, 200)
                                             : $urandom_range(0, 7),
                    $urandom_range(0, 1), $urandom_range(0, 5));
        else
          add_cook();
        // Occasionally cut the payload short or add noise.
        if ($urandom_range(0, 5) == 0 && frame.size() > 2)
          repeat ($urandom_range(1, 2)) void'(frame.pop_back());
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        send_frame();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_recs.size() == 0)
      $display("nested_tlv_status_decoder test passed");
    else
      $display("nested_tlv_status_decoder test failed");
    $finish;
  end

endmodule

[nested_tlv_status_decoder.f]
hw/rtl/ntsd_pkg.sv
hw/rtl/ntsd_front.sv
hw/rtl/ntsd_queue.sv
hw/rtl/ntsd_back.sv
hw/rtl/nested_tlv_status_decoder.sv
hw/rtl/ntsd_checker.sv
sim/testbench.sv
